// ===== design/phq_pkg.sv =====
// Shared types and constants of the priority heap queue.
package phq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int COUNT_W = 7;
    localparam int REC_W = 120;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // record layout: priority, arrival, pid, burst, waiting, response, turnaround, served
    typedef struct packed {
        logic [7:0]  priority_key;
        logic [15:0] arrival_time;
        logic [15:0] proc_id;
        logic [15:0] burst_time;
        logic [15:0] waiting_time;
        logic [15:0] response_time;
        logic [15:0] turnaround_time;
        logic [15:0] served_burst;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RD_ROOT,
        S_DN_RD0,
        S_DN_RD1,
        S_DN_RD2,
        S_DN_CMP,
        S_DN_WR,
        S_RESULT
    } state_t;

    // controller commands to datapath
    typedef struct packed {
        logic load_in;      // capture input item
        logic wr_new;       // write input record at count
        logic up_start;     // set pos to count
        logic rd_parent;    // read parent of pos
        logic up_swap;      // move parent down to pos, pos <- parent
        logic up_place;     // write A at pos
        logic rm_start;     // read last entry into A, pos <- 0
        logic rd_left;      // read left child into B
        logic rd_right;     // read right child
        logic dn_swap;      // move best child up, pos <- best
        logic dn_place;     // write A at pos
        logic cnt_inc;
        logic cnt_dec;
        logic rd_root;      // read root
        logic set_out;      // latch result
        logic out_from_root;
    } cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic a_before_b;   // A precedes the parent just read
        logic has_left;
        logic has_right;
        logic child_better; // best child precedes A
        logic full;
        logic empty;
        logic last_one;     // count == 1
    } sts_t;

    function automatic logic served_before(rec_t a, rec_t b, logic desc);
        if (a.priority_key == b.priority_key) return a.arrival_time < b.arrival_time;
        if (desc) return a.priority_key > b.priority_key;
        return a.priority_key < b.priority_key;
    endfunction

endpackage

// ===== design/phq_ram.sv =====
// Generic single-port RAM with registered read.
module phq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/phq_datapath.sv =====
// Heap datapath: record memory, working registers, count and result.
module phq_datapath #(
    parameter int CAPACITY = phq_pkg::DEFAULT_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   order_mode,
    input  phq_pkg::rec_t          in_rec,
    input  phq_pkg::cmd_t          cmd,
    input  phq_pkg::status_t       res_status,
    output phq_pkg::sts_t          sts,
    output phq_pkg::rec_t          out_rec,
    output logic [phq_pkg::COUNT_W-1:0] out_count
);
    import phq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] ppos_reg, ppos_next;
    logic [AW:0]   left_w, right_w;
    rec_t a_reg, a_next, b_reg, b_next;
    rec_t out_reg, out_next;
    logic          we;
    logic [AW-1:0] addr;
    rec_t          wdata, rdata;
    logic          b_wins_c;
    logic          rd_left_q, rd_parent_q, rd_last_q, rd_root_q;

    phq_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign left_w  = {1'b0, pos_reg} + {1'b0, pos_reg} + {{AW{1'b0}}, 1'b1};
    assign right_w = left_w + {{AW{1'b0}}, 1'b1};
    // right child arrives straight from the RAM output in the compare cycle
    assign b_wins_c = !(sts.has_right && served_before(rdata, b_reg, order_mode));

    // status towards controller
    always_comb begin
        sts.pos_zero     = (pos_reg == '0);
        sts.a_before_b   = served_before(a_reg, rdata, order_mode);
        sts.has_left     = ({1'b0, left_w} < {1'b0, count_reg});
        sts.has_right    = ({1'b0, right_w} < {1'b0, count_reg});
        sts.child_better = b_wins_c ? served_before(b_reg, a_reg, order_mode)
                                    : served_before(rdata, a_reg, order_mode);
        sts.full         = (count_reg == CW'(CAPACITY));
        sts.empty        = (count_reg == '0);
        sts.last_one     = (count_reg == CW'(1));
    end

    // memory port select
    always_comb begin
        we = 1'b0;
        addr = pos_reg;
        wdata = a_reg;
        ppos_next = ppos_reg;
        priority if (cmd.wr_new) begin
            we = 1'b1; addr = count_reg[AW-1:0]; wdata = in_rec;
        end else if (cmd.up_swap) begin
            we = 1'b1; addr = pos_reg; wdata = rdata;
        end else if (cmd.up_place || cmd.dn_place) begin
            we = 1'b1; addr = pos_reg; wdata = a_reg;
        end else if (cmd.dn_swap) begin
            we = 1'b1; addr = pos_reg; wdata = b_wins_c ? b_reg : rdata;
        end else if (cmd.rd_parent) begin
            addr = AW'((pos_reg - AW'(1)) >> 1);
        end else if (cmd.rm_start) begin
            addr = AW'(count_reg - CW'(1));
        end else if (cmd.rd_left) begin
            addr = left_w[AW-1:0];
        end else if (cmd.rd_right) begin
            addr = right_w[AW-1:0];
        end else if (cmd.rd_root) begin
            addr = '0;
        end
        if (cmd.rd_parent) ppos_next = AW'((pos_reg - AW'(1)) >> 1);
    end

    // working register updates
    always_comb begin
        count_next = count_reg;
        pos_next = pos_reg;
        a_next = a_reg;
        b_next = b_reg;
        out_next = out_reg;
        if (cmd.load_in) a_next = in_rec;
        if (cmd.cnt_inc) count_next = count_reg + CW'(1);
        if (cmd.cnt_dec) count_next = count_reg - CW'(1);
        if (cmd.up_start) pos_next = count_reg[AW-1:0];
        if (cmd.up_swap) pos_next = ppos_reg;
        if (cmd.rm_start) pos_next = '0;
        if (cmd.dn_swap) pos_next = b_wins_c ? left_w[AW-1:0] : right_w[AW-1:0];
        if (rd_parent_q || rd_left_q) b_next = rdata;
        if (rd_last_q) a_next = rdata;
        if (rd_root_q) out_next = rdata;
        if (cmd.set_out) out_next = (res_status == ST_OK) ? (cmd.out_from_root ? rdata : out_reg)
                                                          : (cmd.out_from_root ? rdata : '0);
        if (cmd.set_out && res_status == ST_EMPTY) out_next = '0;
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rd_left_q <= 1'b0;
            rd_parent_q <= 1'b0;
            rd_last_q <= 1'b0;
            rd_root_q <= 1'b0;
        end else begin
            count_reg <= count_next;
            rd_left_q <= cmd.rd_left;
            rd_parent_q <= cmd.rd_parent;
            rd_last_q <= cmd.rm_start;
            rd_root_q <= cmd.rd_root;
        end
        pos_reg <= pos_next;
        ppos_reg <= ppos_next;
        a_reg <= a_next;
        b_reg <= b_next;
        out_reg <= out_next;
    end

    assign out_rec = out_reg;
    assign out_count = COUNT_W'(count_reg);
endmodule

// ===== design/phq_ctrl.sv =====
// Heap controller: sequences insert, remove and peek and holds the result handshake.
module phq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    output logic              m_valid,
    input  logic              m_ready,
    input  phq_pkg::sts_t     sts,
    output phq_pkg::cmd_t     cmd,
    output phq_pkg::status_t  res_status
);
    import phq_pkg::*;

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    status_t st_reg, st_next;
    logic    rem_reg, rem_next;   // remove result already latched
    logic    mv_reg, mv_next;
    logic    accept;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign res_status = st_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        st_next = st_reg;
        rem_next = rem_reg;
        mv_next = mv_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next = op_t'(s_operation);
                    rem_next = 1'b0;
                    unique case (op_t'(s_operation))
                        OP_INSERT: begin
                            st_next = sts.full ? ST_FULL : ST_OK;
                            state_next = sts.full ? S_RESULT : S_UP_RD;
                        end
                        OP_REMOVE: begin
                            st_next = sts.empty ? ST_EMPTY : ST_OK;
                            state_next = S_RESULT;
                            if (!sts.empty) begin
                                rem_next = 1'b1;
                                state_next = S_DN_RD0;
                            end
                        end
                        OP_PEEK, OP_SPARE: begin
                            st_next = sts.empty ? ST_EMPTY : ST_OK;
                            state_next = S_RESULT;
                        end
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_UP_RD:   state_next = sts.pos_zero ? S_RD_ROOT : S_UP_CMP;
            S_UP_CMP:  state_next = sts.a_before_b ? S_UP_RD : S_RD_ROOT;
            S_RD_ROOT: state_next = S_RESULT;
            S_DN_RD0:  state_next = sts.last_one ? S_RESULT : S_DN_RD1;
            S_DN_RD1:  state_next = sts.has_left ? S_DN_RD2 : S_DN_WR;
            S_DN_RD2:  state_next = S_DN_CMP;
            S_DN_CMP:  state_next = sts.child_better ? S_DN_RD1 : S_DN_WR;
            S_DN_WR:   state_next = S_RESULT;
            S_RESULT: begin
                state_next = S_IDLE;
                mv_next = 1'b1;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_in = accept;
                cmd.rd_root = accept;
                if (accept && op_t'(s_operation) == OP_INSERT && !sts.full) begin
                    cmd.up_start = 1'b1;
                    cmd.wr_new = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.rd_root = 1'b0;
                end
            end
            // settle the new record at the root once it has climbed there
            S_UP_RD: begin
                cmd.rd_parent = !sts.pos_zero;
                cmd.up_place = sts.pos_zero;
            end
            S_UP_CMP: begin
                cmd.up_swap = sts.a_before_b;
                cmd.up_place = !sts.a_before_b;
            end
            // fetch the root once the heap is settled
            S_RD_ROOT: cmd.rd_root = 1'b1;
            S_DN_RD0: begin
                cmd.rm_start = !sts.last_one;
                cmd.cnt_dec = 1'b1;
            end
            S_DN_RD1: cmd.rd_left = sts.has_left;
            S_DN_RD2: cmd.rd_right = sts.has_right;
            S_DN_CMP: begin
                cmd.dn_swap = sts.child_better;
                cmd.dn_place = !sts.child_better;
            end
            S_DN_WR:  cmd.dn_place = rem_reg;
            S_RESULT: begin
                cmd.rd_root = 1'b0;
                cmd.set_out = 1'b1;
                cmd.out_from_root = (op_reg != OP_REMOVE);
            end
            default: cmd = '0;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
            rem_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            rem_reg <= rem_next;
        end
        op_reg <= op_next;
        st_reg <= st_next;
    end
endmodule

// ===== design/priority_heap_queue_top.sv =====
// Top level of the priority heap queue.
// A binary-heap priority queue of up to CAPACITY records held in one single-port RAM with
// registered read; one item is handled at a time and every step is paced by that one port.
// An insert writes the record at the end and climbs one level per parent read and compare until
// it reaches the root or a parent that goes first; a remove moves the last entry to the root and
// descends one level per left read, right read and compare until it reaches a leaf or no child
// goes first. A peek, a remove or peek on an empty queue and a rejected insert go straight to the
// result. The result waits in an output register and s_ready returns the cycle after it is
// delivered. The user must write order_mode only while the block is idle; the block itself
// leaves this rule to the user.
module priority_heap_queue_top #(
    parameter int CAPACITY = phq_pkg::DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_proc_id,
    input  logic [15:0] s_arrival_time,
    input  logic [15:0] s_burst_time,
    input  logic [7:0]  s_priority_req,
    input  logic [15:0] s_waiting_time,
    input  logic [15:0] s_response_time,
    input  logic [15:0] s_turnaround_time,
    input  logic [15:0] s_served_burst,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_out_proc_id,
    output logic [15:0] m_out_arrival_time,
    output logic [15:0] m_out_burst_time,
    output logic [7:0]  m_out_priority,
    output logic [15:0] m_out_waiting_time,
    output logic [15:0] m_out_response_time,
    output logic [15:0] m_out_turnaround_time,
    output logic [15:0] m_out_served_burst,
    output logic [6:0]  m_count
);
    import phq_pkg::*;

    logic    order_mode_reg;
    rec_t    in_rec, out_rec;
    cmd_t    cmd;
    sts_t    sts;
    status_t res_status;

    // hold the ordering mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            order_mode_reg <= cfg_wdata;
        end
    end

    always_comb begin
        in_rec.priority_key    = s_priority_req;
        in_rec.arrival_time    = s_arrival_time;
        in_rec.proc_id         = s_proc_id;
        in_rec.burst_time      = s_burst_time;
        in_rec.waiting_time    = s_waiting_time;
        in_rec.response_time   = s_response_time;
        in_rec.turnaround_time = s_turnaround_time;
        in_rec.served_burst    = s_served_burst;
    end

    phq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd), .res_status(res_status)
    );

    phq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .order_mode(order_mode_reg), .in_rec(in_rec),
        .cmd(cmd), .res_status(res_status), .sts(sts), .out_rec(out_rec),
        .out_count(m_count)
    );

    assign m_status              = res_status;
    assign m_out_proc_id         = out_rec.proc_id;
    assign m_out_arrival_time    = out_rec.arrival_time;
    assign m_out_burst_time      = out_rec.burst_time;
    assign m_out_priority        = out_rec.priority_key;
    assign m_out_waiting_time    = out_rec.waiting_time;
    assign m_out_response_time   = out_rec.response_time;
    assign m_out_turnaround_time = out_rec.turnaround_time;
    assign m_out_served_burst    = out_rec.served_burst;
endmodule

// ===== verif/phq_checker.sv =====
// Checker for the priority heap queue: watches both channels, predicts and compares results.
module phq_checker
    import phq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_proc_id,
    input  logic [15:0] s_arrival_time,
    input  logic [15:0] s_burst_time,
    input  logic [7:0]  s_priority_req,
    input  logic [15:0] s_waiting_time,
    input  logic [15:0] s_response_time,
    input  logic [15:0] s_turnaround_time,
    input  logic [15:0] s_served_burst,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_out_proc_id,
    input  logic [15:0] m_out_arrival_time,
    input  logic [15:0] m_out_burst_time,
    input  logic [7:0]  m_out_priority,
    input  logic [15:0] m_out_waiting_time,
    input  logic [15:0] m_out_response_time,
    input  logic [15:0] m_out_turnaround_time,
    input  logic [15:0] m_out_served_burst,
    input  logic [6:0]  m_count,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t    status;
        rec_t       top;
        logic [6:0] count;
    } reply_t;

    rec_t   heap_mem [CAPACITY];
    int     held;
    logic   descending;
    reply_t reply_q [$];

    assign pending = reply_q.size();

    function automatic logic goes_first(rec_t a, rec_t b);
        if (a.priority_key == b.priority_key) return a.arrival_time < b.arrival_time;
        if (descending) return a.priority_key > b.priority_key;
        return a.priority_key < b.priority_key;
    endfunction

    // Apply one operation to the shadow heap and return its expected reply
    function automatic reply_t heap_apply(logic [1:0] op, rec_t rec);
        reply_t r;
        rec_t   t;
        int     p, best, l, c;
        r = '0;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (held >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                p = held;
                heap_mem[p] = rec;
                held++;
                while (p > 0 && goes_first(heap_mem[p], heap_mem[(p - 1) / 2])) begin
                    t = heap_mem[p];
                    heap_mem[p] = heap_mem[(p - 1) / 2];
                    heap_mem[(p - 1) / 2] = t;
                    p = (p - 1) / 2;
                end
            end
            if (held > 0) r.top = heap_mem[0];
        end else if (op == OP_REMOVE) begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.top = heap_mem[0];
                held--;
                if (held > 0) begin
                    heap_mem[0] = heap_mem[held];
                    p = 0;
                    forever begin
                        best = p;
                        l = 2 * p + 1;
                        c = 2 * p + 2;
                        if (l < held && goes_first(heap_mem[l], heap_mem[best])) best = l;
                        if (c < held && goes_first(heap_mem[c], heap_mem[best])) best = c;
                        if (best == p) break;
                        t = heap_mem[best];
                        heap_mem[best] = heap_mem[p];
                        heap_mem[p] = t;
                        p = best;
                    end
                end
            end
        end else begin
            if (held == 0) r.status = ST_EMPTY;
            else r.top = heap_mem[0];
        end
        r.count = held[6:0];
        return r;
    endfunction

    // Predict on accepted items, compare on delivered ones
    always @(posedge aclk) begin
        rec_t   rin;
        reply_t want;
        if (!aresetn) begin
            held = 0;
            descending = 1'b0;
            reply_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) descending = cfg_wdata;
            if (s_valid && s_ready) begin
                rin = '{s_priority_req, s_arrival_time, s_proc_id, s_burst_time,
                        s_waiting_time, s_response_time, s_turnaround_time, s_served_burst};
                reply_q.push_back(heap_apply(s_operation, rin));
            end
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected result item");
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, m_status); fail_count++;
                    end
                    if (m_out_proc_id !== want.top.proc_id) begin
                        $error("out_proc_id exp %0h got %0h", want.top.proc_id, m_out_proc_id);
                        fail_count++;
                    end
                    if (m_out_arrival_time !== want.top.arrival_time) begin
                        $error("out_arrival_time exp %0h got %0h", want.top.arrival_time,
                               m_out_arrival_time);
                        fail_count++;
                    end
                    if (m_out_burst_time !== want.top.burst_time) begin
                        $error("out_burst_time exp %0h got %0h", want.top.burst_time,
                               m_out_burst_time);
                        fail_count++;
                    end
                    if (m_out_priority !== want.top.priority_key) begin
                        $error("out_priority exp %0h got %0h", want.top.priority_key,
                               m_out_priority);
                        fail_count++;
                    end
                    if (m_out_waiting_time !== want.top.waiting_time) begin
                        $error("out_waiting_time exp %0h got %0h", want.top.waiting_time,
                               m_out_waiting_time);
                        fail_count++;
                    end
                    if (m_out_response_time !== want.top.response_time) begin
                        $error("out_response_time exp %0h got %0h", want.top.response_time,
                               m_out_response_time);
                        fail_count++;
                    end
                    if (m_out_turnaround_time !== want.top.turnaround_time) begin
                        $error("out_turnaround_time exp %0h got %0h",
                               want.top.turnaround_time, m_out_turnaround_time);
                        fail_count++;
                    end
                    if (m_out_served_burst !== want.top.served_burst) begin
                        $error("out_served_burst exp %0h got %0h", want.top.served_burst,
                               m_out_served_burst);
                        fail_count++;
                    end
                    if (m_count !== want.count) begin
                        $error("count exp %0d got %0d", want.count, m_count); fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/testbench.sv =====
// Stimulus and verdict for the priority heap queue.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import phq_pkg::*;

    localparam int CAP = DEFAULT_CAPACITY;
    localparam int LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_PEEK;
    logic [15:0] s_proc_id = '0, s_arrival_time = '0, s_burst_time = '0;
    logic [7:0]  s_priority_req = '0;
    logic [15:0] s_waiting_time = '0, s_response_time = '0;
    logic [15:0] s_turnaround_time = '0, s_served_burst = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_out_proc_id, m_out_arrival_time, m_out_burst_time;
    logic [7:0]  m_out_priority;
    logic [15:0] m_out_waiting_time, m_out_response_time;
    logic [15:0] m_out_turnaround_time, m_out_served_burst;
    logic [6:0]  m_count;
    int          fail_count, pending;
    int          cycles = 0;
    bit          calm = 1'b0;
    int          model_held = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    priority_heap_queue_top #(.CAPACITY(CAP)) DUT (.*);
    phq_checker #(.CAPACITY(CAP)) checker_i (.*);

    // Hard stop on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: ready in random bursts, steady at the end
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= $urandom_range(0, 1);
                n = $urandom_range(1, 7);
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    // Present one item and hold it until accepted; valid drops only ahead of a gap
    task automatic send_item(logic [1:0] op, logic [7:0] pri, logic [15:0] at, bit rnd);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_priority_req <= pri;
        s_arrival_time <= at;
        s_proc_id <= rnd ? 16'($urandom) : 16'hFFFF;
        s_burst_time <= rnd ? 16'($urandom) : 16'hFFFF;
        s_waiting_time <= rnd ? 16'($urandom) : 16'h0000;
        s_response_time <= rnd ? 16'($urandom) : 16'hFFFF;
        s_turnaround_time <= rnd ? 16'($urandom) : 16'h0000;
        s_served_burst <= rnd ? 16'($urandom) : 16'hFFFF;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (op == OP_INSERT && model_held < CAP) model_held++;
        else if (op == OP_REMOVE && model_held > 0) model_held--;
    endtask

    // Drain and change the order mode while idle
    task automatic set_order(logic mode);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int fill;
        logic [1:0] op;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queue, extremes, ties, full queue, spare code
        send_item(OP_REMOVE, 8'd0, 16'd0, 0);
        send_item(OP_PEEK, 8'd0, 16'd0, 0);
        send_item(OP_SPARE, 8'd0, 16'd0, 0);
        send_item(OP_INSERT, 8'hFF, 16'hFFFF, 0);
        send_item(OP_INSERT, 8'h00, 16'h0000, 0);
        send_item(OP_INSERT, 8'h00, 16'h0001, 1);
        send_item(OP_INSERT, 8'h80, 16'h0000, 1);
        send_item(OP_PEEK, 8'd0, 16'd0, 0);
        send_item(OP_SPARE, 8'd0, 16'd0, 1);
        repeat (4) send_item(OP_REMOVE, 8'd0, 16'd0, 0);
        send_item(OP_REMOVE, 8'd0, 16'd0, 0);
        for (int i = 0; i < CAP; i++) send_item(OP_INSERT, 8'($urandom_range(0, 3)),
                                                16'($urandom_range(0, 7)), 1);
        send_item(OP_INSERT, 8'h00, 16'h0000, 1);
        set_order(1'b1);
        send_item(OP_INSERT, 8'hFF, 16'h0000, 1);
        for (int i = 0; i < CAP; i++) send_item(OP_REMOVE, 8'd0, 16'd0, 0);

        // Random phases with mode changes; mix fill and drain runs
        for (int ph = 0; ph < 8; ph++) begin
            set_order(ph[0]);
            if (ph == 7) calm = 1'b1;
            for (int i = 0; i < 250; i++) begin
                fill = (i / 40) % 2;
                case ($urandom_range(0, 9))
                    0: op = OP_PEEK;
                    1: op = 2'($urandom_range(2, 3));
                    2, 3, 4, 5: op = fill ? OP_INSERT : OP_REMOVE;
                    default: op = fill ? OP_REMOVE : OP_INSERT;
                endcase
                if (model_held >= CAP - 2 && $urandom_range(0, 1)) op = OP_INSERT;
                send_item(op, ($urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                                    : 8'($urandom)),
                          ($urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                                : 16'($urandom)), 1);
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
